// File: src/bmpm_pkg.sv
`timescale 1ns / 1ps

package bmpm_pkg;

  // Row and palette limits.
  localparam int unsigned MAX_WIDTH    = 2048;
  localparam int unsigned PALETTE_SIZE = 256;
  localparam int unsigned PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int unsigned COL_W        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DRAW_W       = 12;
  localparam int unsigned CFG_W        = 12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PIXEL_DEPTH = 2'd0;
  localparam logic [1:0] CFG_USE_565     = 2'd1;
  localparam logic [1:0] CFG_COLOR_MODE  = 2'd2;
  localparam logic [1:0] CFG_DRAW_WIDTH  = 2'd3;

  // Supported pixel depths.
  localparam logic [4:0] DEPTH_1  = 5'd1;
  localparam logic [4:0] DEPTH_4  = 5'd4;
  localparam logic [4:0] DEPTH_8  = 5'd8;
  localparam logic [4:0] DEPTH_16 = 5'd16;
  localparam logic [4:0] DEPTH_24 = 5'd24;

  // Input mode codes.
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_DATA    = 1'b1;

  // Classification thresholds.
  localparam logic [7:0] WHITE_LEVEL = 8'h80;
  localparam logic [9:0] WHITE_SUM   = 10'd384;
  localparam logic [7:0] COLOR_LEVEL = 8'hF0;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    logic [4:0]       depth;
    logic             use_565;
    logic             color_on;
    logic [COL_W-1:0] width;
  } cfg_t;

  // Item held in the input register.
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } s1_t;

  // Pixels decoded from one row byte, index 0 is leftmost.
  typedef struct packed {
    logic [3:0] count;
    logic [7:0] white;
    logic [7:0] colored;
  } pix_t;

  // Returns {whitish, colored} for one RGB triple.
  function automatic logic [1:0] classify(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic color_on);
    logic [9:0] sum;
    logic       wht;
    logic       col;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    if (color_on) begin
      wht = (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
    end else begin
      wht = sum > WHITE_SUM;
    end
    col = (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
    return {wht, col};
  endfunction

endpackage

// File: src/bmpm_ram.sv
`timescale 1ns / 1ps

module bmpm_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports that hold while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: src/bmpm_unpack.sv
`timescale 1ns / 1ps

module bmpm_unpack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  bmpm_pkg::cfg_t  cfg,
  input  bmpm_pkg::s1_t   s1,
  input  logic [1:0]      ent_a,
  input  logic [1:0]      ent_b,
  output bmpm_pkg::pix_t  pix
);

  import bmpm_pkg::*;

  logic [15:0] held_r, held_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  lsb;
  logic [7:0]  r16, g16, b16;
  logic [1:0]  cls16, cls24;

  // 16-bit pixel fields, scaled to eight bits.
  always_comb begin
    lsb = held_r[7:0];
    b16 = {lsb[4:0], 3'b000};
    if (cfg.use_565) begin
      g16 = {s1.data[2:0], lsb[7:5], 2'b00};
      r16 = {s1.data[7:3], 3'b000};
    end else begin
      g16 = {s1.data[1:0], lsb[7:5], 3'b000};
      r16 = {s1.data[6:2], 3'b000};
    end
  end

  assign cls16 = classify(r16, g16, b16, cfg.color_on);
  assign cls24 = classify(s1.data, held_r[15:8], held_r[7:0], cfg.color_on);

  // Pixel decode and byte gathering for the multi-byte depths.
  always_comb begin
    pix       = '0;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    if (s1.mode == MODE_DATA) begin
      case (cfg.depth)
        DEPTH_1: begin
          pix.count = 4'd8;
          for (int k = 0; k < 8; k++) begin
            pix.white[k]   = s1.data[7-k] ? ent_b[1] : ent_a[1];
            pix.colored[k] = s1.data[7-k] ? ent_b[0] : ent_a[0];
          end
        end
        DEPTH_4: begin
          pix.count      = 4'd2;
          pix.white[0]   = ent_a[1];
          pix.colored[0] = ent_a[0];
          pix.white[1]   = ent_b[1];
          pix.colored[1] = ent_b[0];
        end
        DEPTH_8: begin
          pix.count      = 4'd1;
          pix.white[0]   = ent_a[1];
          pix.colored[0] = ent_a[0];
        end
        DEPTH_16: begin
          if (phase_r == 2'd0) begin
            held_nxt  = {8'h00, s1.data};
            phase_nxt = 2'd1;
          end else begin
            pix.count      = 4'd1;
            pix.white[0]   = cls16[1];
            pix.colored[0] = cls16[0];
            held_nxt       = '0;
            phase_nxt      = 2'd0;
          end
        end
        DEPTH_24: begin
          if (phase_r == 2'd0) begin
            held_nxt  = {8'h00, s1.data};
            phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            held_nxt  = {s1.data, held_r[7:0]};
            phase_nxt = 2'd2;
          end else begin
            pix.count      = 4'd1;
            pix.white[0]   = cls24[1];
            pix.colored[0] = cls24[0];
            held_nxt       = '0;
            phase_nxt      = 2'd0;
          end
        end
        default: begin
          // Unsupported depth: each byte is one white pixel.
          pix.count    = 4'd1;
          pix.white[0] = 1'b1;
        end
      endcase
      if (s1.last) begin
        held_nxt  = '0;
        phase_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      phase_r <= '0;
    end else if (adv) begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: src/bmpm_pack.sv
`timescale 1ns / 1ps

module bmpm_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            out_stall,
  input  bmpm_pkg::cfg_t  cfg,
  input  bmpm_pkg::s1_t   s1,
  input  bmpm_pkg::pix_t  pix,
  output logic            out_valid,
  output logic [7:0]      out_mono_byte,
  output logic [7:0]      out_colored_byte,
  output logic [7:0]      out_byte_index,
  output logic            out_row_done
);

  import bmpm_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [7:0]       mono_r, mono_nxt;
  logic [7:0]       color_r, color_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic             out_valid_r;
  logic [7:0]       out_mono_r, out_color_r, out_index_r;
  logic             out_done_r;

  logic [COL_W:0]   colk;
  logic [COL_W:0]   wlast;
  logic [7:0]       bitk;
  logic             emit;
  logic [7:0]       om, oc, oidx;
  logic             olast;

  assign wlast = {1'b0, cfg.width} - (COL_W+1)'(1);

  // Place up to eight pixels; the last completed byte in this item is the result.
  always_comb begin
    mono_nxt  = mono_r;
    color_nxt = color_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    emit      = 1'b0;
    om        = 8'hFF;
    oc        = 8'hFF;
    oidx      = 8'h00;
    olast     = 1'b0;
    colk      = '0;
    bitk      = '0;
    for (int k = 0; k < 8; k++) begin
      colk = {1'b0, col_r} + (COL_W+1)'(k);
      if ((4'(k) < pix.count) && (colk < {1'b0, cfg.width})) begin
        bitk = 8'h80 >> colk[2:0];
        if (!pix.white[k]) begin
          if (pix.colored[k] && cfg.color_on) begin
            color_nxt = color_nxt & ~bitk;
          end else begin
            mono_nxt = mono_nxt & ~bitk;
          end
        end
        col_nxt = COL_W'(colk + (COL_W+1)'(1));
        if ((colk[2:0] == 3'd7) || (colk == wlast)) begin
          emit      = 1'b1;
          om        = mono_nxt;
          oc        = color_nxt;
          oidx      = pos_nxt;
          olast     = (colk == wlast);
          pos_nxt   = pos_nxt + 8'd1;
          mono_nxt  = 8'hFF;
          color_nxt = 8'hFF;
        end
      end
    end
    // Row end clears the row state after this byte is placed.
    if (s1.last) begin
      col_nxt   = '0;
      mono_nxt  = 8'hFF;
      color_nxt = 8'hFF;
      pos_nxt   = 8'h00;
    end
  end

  // Row state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= '0;
      mono_r      <= 8'hFF;
      color_r     <= 8'hFF;
      pos_r       <= 8'h00;
    end else begin
      if (adv) begin
        out_valid_r <= emit;
        if (s1.mode == MODE_DATA) begin
          col_r   <= col_nxt;
          mono_r  <= mono_nxt;
          color_r <= color_nxt;
          pos_r   <= pos_nxt;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_mono_r  <= om;
      out_color_r <= oc;
      out_index_r <= oidx;
      out_done_r  <= olast;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mono_byte    = out_mono_r;
  assign out_colored_byte = out_color_r;
  assign out_byte_index   = out_index_r;
  assign out_row_done     = out_done_r;

endmodule

// File: src/bmp_row_to_mono_color_bits.sv
`timescale 1ns / 1ps
// Channel   | Ports                                              | Transfer
// ----------+----------------------------------------------------+------------------------
// input     | in_mode, in_palette_index, in_pal_*, in_data_byte,  | in_valid && !in_stall
//           | in_row_last                                        |
// result    | out_mono_byte, out_colored_byte, out_byte_index,   | out_valid && !out_stall
//           | out_row_done                                       |
// config    | cfg_index, cfg_wdata                               | cfg_we
//
// One item per cycle is taken unless in_stall is high; each completed byte gives a result.
// The transfer edge registers the item and reads two palette entries from the RAM;
// when the input stage advances, pixels are decoded and packed into the result register.
// Reset (synchronous, active low) clears row state and pipeline valids; the palette
// holds nothing until loaded. A stalled result holds the input stage, which then
// stalls the input channel.

module bmp_row_to_mono_color_bits (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bmpm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic [7:0]                in_palette_index,
  input  logic [7:0]                in_pal_red,
  input  logic [7:0]                in_pal_green,
  input  logic [7:0]                in_pal_blue,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_row_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_mono_byte,
  output logic [7:0]                out_colored_byte,
  output logic [7:0]                out_byte_index,
  output logic                      out_row_done
);

  import bmpm_pkg::*;

  logic [4:0]        depth_r;
  logic              use565_r;
  logic              color_mode_r;
  logic [DRAW_W-1:0] draw_width_r;
  cfg_t              cfg;

  logic              s1_valid_r;
  s1_t               s1_r;
  logic              in_xfer;
  logic              adv;

  logic              pal_we;
  logic              pal_re;
  logic [PAL_AW-1:0] raddr_a, raddr_b;
  logic [1:0]        ent_a, ent_b;
  pix_t              pix;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= DEPTH_24;
      use565_r     <= 1'b0;
      color_mode_r <= 1'b0;
      draw_width_r <= DRAW_W'(200);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_DEPTH: depth_r      <= cfg_wdata[4:0];
        CFG_USE_565:     use565_r     <= cfg_wdata[0];
        CFG_COLOR_MODE:  color_mode_r <= cfg_wdata[0];
        CFG_DRAW_WIDTH:  draw_width_r <= cfg_wdata[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Depth 1 forces color off; width saturates at MAX_WIDTH.
  always_comb begin
    cfg.depth    = depth_r;
    cfg.use_565  = use565_r;
    cfg.color_on = color_mode_r && (depth_r != DEPTH_1);
    cfg.width    = (draw_width_r > DRAW_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                                       : COL_W'(draw_width_r);
  end

  // Input register handshake.
  assign adv      = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.mode <= in_mode;
      s1_r.data <= in_data_byte;
      s1_r.last <= in_row_last;
    end
  end

  // Palette load and lookup addresses.
  assign pal_we = in_xfer && (in_mode == MODE_PALETTE);
  assign pal_re = in_xfer && (in_mode == MODE_DATA);

  always_comb begin
    case (depth_r)
      DEPTH_1: begin
        raddr_a = PAL_AW'(0);
        raddr_b = PAL_AW'(1);
      end
      DEPTH_4: begin
        raddr_a = PAL_AW'(in_data_byte[7:4]);
        raddr_b = PAL_AW'(in_data_byte[3:0]);
      end
      default: begin
        raddr_a = PAL_AW'(in_data_byte);
        raddr_b = PAL_AW'(in_data_byte);
      end
    endcase
  end

  bmpm_ram #(
    .WIDTH (2),
    .DEPTH (PALETTE_SIZE)
  ) u_pal (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (PAL_AW'(in_palette_index)),
    .wdata   (classify(in_pal_red, in_pal_green, in_pal_blue, cfg.color_on)),
    .re      (pal_re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ent_a),
    .rdata_b (ent_b)
  );

  bmpm_unpack u_unpack (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .s1    (s1_r),
    .ent_a (ent_a),
    .ent_b (ent_b),
    .pix   (pix)
  );

  bmpm_pack u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .out_stall        (out_stall),
    .cfg              (cfg),
    .s1               (s1_r),
    .pix              (pix),
    .out_valid        (out_valid),
    .out_mono_byte    (out_mono_byte),
    .out_colored_byte (out_colored_byte),
    .out_byte_index   (out_byte_index),
    .out_row_done     (out_row_done)
  );

endmodule

// File: src/bmpm_check.sv
`timescale 1ns / 1ps

module bmpm_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_we,
  input logic [1:0]                 cfg_index,
  input logic [bmpm_pkg::CFG_W-1:0] cfg_wdata,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_mode,
  input logic [7:0]                 in_palette_index,
  input logic [7:0]                 in_pal_red,
  input logic [7:0]                 in_pal_green,
  input logic [7:0]                 in_pal_blue,
  input logic [7:0]                 in_data_byte,
  input logic                       in_row_last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_mono_byte,
  input logic [7:0]                 out_colored_byte,
  input logic [7:0]                 out_byte_index,
  input logic                       out_row_done
);

  import bmpm_pkg::*;

  // Reset empties both pipeline stages.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A palette load never produces a result.
  a_palette_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_PALETTE)) ##1 !out_valid |=> !out_valid)
    else $error("palette load produced a result");

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mono_byte)
      && $stable(out_colored_byte) && $stable(out_byte_index) && $stable(out_row_done))
    else $error("stalled result changed");

endmodule

bind bmp_row_to_mono_color_bits bmpm_check u_check (.*);
